// ===== rtl/core/point_region_obstacle_detector_unit_macros.svh =====
// Assertion macros for the point region obstacle detector.
`ifndef POINT_REGION_OBSTACLE_DETECTOR_UNIT_MACROS_SVH
`define POINT_REGION_OBSTACLE_DETECTOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define PORD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression that must never be true outside reset.
`define PORD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PORD_ASSERT(lbl, prop, msg)
`define PORD_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/core/pord_pkg.sv =====
// Shared types and constants of the point region obstacle detector.
package pord_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int BAND_BITS      = 15;
    localparam int RADIUS_BITS    = 32;
    localparam int COUNT_BITS     = 16;
    localparam int ADDR_BITS      = 4;
    localparam int DATA_BITS      = 32;

    localparam logic [BAND_BITS-1:0]   BAND_FLOOR_RST  = 15'd15;
    localparam logic [BAND_BITS-1:0]   BAND_HEIGHT_RST = 15'd60;
    localparam logic [RADIUS_BITS-1:0] RADIUS_SQ_RST   = 32'd52900;
    localparam logic [COUNT_BITS-1:0]  THRESHOLD_RST   = 16'd750;

    typedef enum logic [1:0] {
        REG_BAND_FLOOR  = 2'd0,
        REG_BAND_HEIGHT = 2'd1,
        REG_RADIUS_SQ   = 2'd2,
        REG_THRESHOLD   = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_FIN    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic update;
        logic fin;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_pending;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/pord_cfg.sv =====
// Configuration register file with APB-style access.
module pord_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pord_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [pord_pkg::DATA_BITS-1:0]        pwdata,
    output logic [pord_pkg::DATA_BITS-1:0]        prdata,
    output logic                                  pready,
    output logic [pord_pkg::BAND_BITS-1:0]        band_floor,
    output logic [pord_pkg::BAND_BITS-1:0]        band_height,
    output logic [pord_pkg::RADIUS_BITS-1:0]      radius_squared,
    output logic [pord_pkg::COUNT_BITS-1:0]       count_threshold
);
    import pord_pkg::*;

    logic [BAND_BITS-1:0]   band_floor_reg;
    logic [BAND_BITS-1:0]   band_height_reg;
    logic [RADIUS_BITS-1:0] radius_sq_reg;
    logic [COUNT_BITS-1:0]  threshold_reg;
    logic                   wr_en;
    reg_idx_t               idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_floor_reg  <= BAND_FLOOR_RST;
            band_height_reg <= BAND_HEIGHT_RST;
            radius_sq_reg   <= RADIUS_SQ_RST;
            threshold_reg   <= THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_BAND_FLOOR:  band_floor_reg  <= pwdata[BAND_BITS-1:0];
                REG_BAND_HEIGHT: band_height_reg <= pwdata[BAND_BITS-1:0];
                REG_RADIUS_SQ:   radius_sq_reg   <= pwdata[RADIUS_BITS-1:0];
                REG_THRESHOLD:   threshold_reg   <= pwdata[COUNT_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BAND_FLOOR:  prdata = DATA_BITS'(band_floor_reg);
            REG_BAND_HEIGHT: prdata = DATA_BITS'(band_height_reg);
            REG_RADIUS_SQ:   prdata = DATA_BITS'(radius_sq_reg);
            REG_THRESHOLD:   prdata = DATA_BITS'(threshold_reg);
        endcase
    end

    assign band_floor      = band_floor_reg;
    assign band_height     = band_height_reg;
    assign radius_squared  = radius_sq_reg;
    assign count_threshold = threshold_reg;

endmodule

// ===== rtl/core/pord_div.sv =====
// Shift-subtract signed divider, one quotient bit per step, truncating toward zero.
module pord_div #(
    parameter int DIVIDEND_BITS = pord_pkg::COORD_BITS_DEF + pord_pkg::COUNT_BITS,
    parameter int DIVISOR_BITS  = pord_pkg::COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            start,
    input  logic                            step,
    input  logic signed [DIVIDEND_BITS-1:0] dividend,
    input  logic        [DIVISOR_BITS-1:0]  divisor,
    output logic signed [DIVIDEND_BITS-1:0] quotient
);
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  div_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    diff;
    logic                     ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend[DIVIDEND_BITS-1] ? -dividend : dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            neg_reg  <= dividend[DIVIDEND_BITS-1];
            zero_reg <= (divisor == '0);
        end
        else if (step)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
        end
    end

    always_comb
    begin
        if (zero_reg)
            quotient = '0;
        else if (neg_reg)
            quotient = -$signed(quo_reg);
        else
            quotient = $signed(quo_reg);
    end

endmodule

// ===== rtl/core/pord_dp.sv =====
// Datapath: point registers, region test, per-frame accumulators, dividers, output beat.
module pord_dp #(
    parameter int COORD_BITS = pord_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pord_pkg::dp_cmd_t                  cmd,
    output pord_pkg::dp_status_t               status,
    input  logic [pord_pkg::BAND_BITS-1:0]     band_floor,
    input  logic [pord_pkg::BAND_BITS-1:0]     band_height,
    input  logic [pord_pkg::RADIUS_BITS-1:0]   radius_squared,
    input  logic [pord_pkg::COUNT_BITS-1:0]    count_threshold,
    input  logic signed [COORD_BITS-1:0]       point_x,
    input  logic signed [COORD_BITS-1:0]       point_y,
    input  logic signed [COORD_BITS-1:0]       point_z,
    input  logic                               point_valid,
    input  logic                               frame_last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               obstacle_found,
    output logic signed [COORD_BITS-1:0]       left_x,
    output logic signed [COORD_BITS-1:0]       left_y,
    output logic signed [COORD_BITS-1:0]       right_x,
    output logic signed [COORD_BITS-1:0]       right_y,
    output logic signed [COORD_BITS-1:0]       mean_x,
    output logic signed [COORD_BITS-1:0]       mean_y,
    output logic [pord_pkg::COUNT_BITS-1:0]    hit_count
);
    import pord_pkg::*;

    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int R2_BITS  = ((SQ_BITS > RADIUS_BITS) ? SQ_BITS : RADIUS_BITS) + 1;
    localparam int SUM_BITS = COORD_BITS + COUNT_BITS;
    localparam int CMP_BITS = ((COORD_BITS > BAND_BITS + 1) ? COORD_BITS : BAND_BITS + 1) + 1;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // captured point
    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic                         valid_reg;
    logic                         last_reg;
    logic [SQ_BITS-1:0]           sqx_reg, sqy_reg;
    logic signed [SQ_BITS-1:0]    sqx_full, sqy_full;

    // frame state
    logic [COUNT_BITS-1:0]        hits_reg;
    logic                         sat_reg;
    logic signed [SUM_BITS-1:0]   sum_x_reg, sum_y_reg;
    logic signed [COORD_BITS-1:0] least_y_reg, least_y_x_reg, most_y_reg, most_y_x_reg;

    // frame snapshot for the result
    logic                         res_found_reg;
    logic [COUNT_BITS-1:0]        res_hits_reg;
    logic signed [COORD_BITS-1:0] res_left_x_reg, res_left_y_reg;
    logic signed [COORD_BITS-1:0] res_right_x_reg, res_right_y_reg;

    // output beat
    logic                         out_valid_reg;
    logic                         out_found_reg;
    logic [COUNT_BITS-1:0]        out_hits_reg;
    logic signed [COORD_BITS-1:0] out_left_x_reg, out_left_y_reg;
    logic signed [COORD_BITS-1:0] out_right_x_reg, out_right_y_reg;
    logic signed [COORD_BITS-1:0] out_mean_x_reg, out_mean_y_reg;

    logic signed [CMP_BITS-1:0]   z_ext, lo_ext, hi_ext;
    logic [BAND_BITS:0]           band_top;
    logic [R2_BITS-1:0]           r2;
    logic                         in_band, in_radius, hit;
    logic [COUNT_BITS:0]          hits_inc;
    logic                         reach;
    logic [COUNT_BITS-1:0]        acc;
    logic signed [SUM_BITS-1:0]   quo_x, quo_y;

    assign sqx_full = point_x * point_x;
    assign sqy_full = point_y * point_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 1'b0;
        else if (cmd.load_in)
            last_reg <= frame_last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg     <= point_x;
            y_reg     <= point_y;
            z_reg     <= point_z;
            valid_reg <= point_valid;
            sqx_reg   <= sqx_full;
            sqy_reg   <= sqy_full;
        end
    end

    assign band_top  = {1'b0, band_floor} + {1'b0, band_height};
    assign z_ext     = CMP_BITS'(z_reg);
    assign lo_ext    = $signed(CMP_BITS'(band_floor));
    assign hi_ext    = $signed(CMP_BITS'(band_top));
    assign in_band   = (z_ext >= lo_ext) && (z_ext < hi_ext);
    assign r2        = R2_BITS'(sqx_reg) + R2_BITS'(sqy_reg);
    assign in_radius = r2 < R2_BITS'(radius_squared);
    assign hit       = valid_reg && !sat_reg && in_band && in_radius;
    assign hits_inc  = {1'b0, hits_reg} + (COUNT_BITS+1)'(1);
    assign reach     = hits_inc >= {1'b0, count_threshold};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            sat_reg       <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            least_y_reg   <= COORD_MAX;
            least_y_x_reg <= '0;
            most_y_reg    <= COORD_MIN;
            most_y_x_reg  <= '0;
        end
        else if (cmd.fin)
        begin
            hits_reg      <= '0;
            sat_reg       <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            least_y_reg   <= COORD_MAX;
            least_y_x_reg <= '0;
            most_y_reg    <= COORD_MIN;
            most_y_x_reg  <= '0;
        end
        else if (cmd.update && hit)
        begin
            hits_reg <= hits_inc[COUNT_BITS-1:0];
            if (reach)
                sat_reg <= 1'b1;
            else
            begin
                sum_x_reg <= sum_x_reg + SUM_BITS'(x_reg);
                sum_y_reg <= sum_y_reg + SUM_BITS'(y_reg);
                if (y_reg <= least_y_reg)
                begin
                    least_y_reg   <= y_reg;
                    least_y_x_reg <= x_reg;
                end
                if (y_reg >= most_y_reg)
                begin
                    most_y_reg   <= y_reg;
                    most_y_x_reg <= x_reg;
                end
            end
        end
    end

    // the point that reaches the threshold is counted but not summed
    assign acc = sat_reg ? hits_reg - COUNT_BITS'(1) : hits_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            res_found_reg   <= hits_reg >= count_threshold;
            res_hits_reg    <= hits_reg;
            res_left_x_reg  <= least_y_x_reg;
            res_left_y_reg  <= least_y_reg;
            res_right_x_reg <= most_y_x_reg;
            res_right_y_reg <= most_y_reg;
        end
    end

    pord_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_div_x (
        .clk      (clk),
        .start    (cmd.fin),
        .step     (cmd.div_step),
        .dividend (sum_x_reg),
        .divisor  (acc),
        .quotient (quo_x)
    );

    pord_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_div_y (
        .clk      (clk),
        .start    (cmd.fin),
        .step     (cmd.div_step),
        .dividend (sum_y_reg),
        .divisor  (acc),
        .quotient (quo_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg   <= res_found_reg;
            out_hits_reg    <= res_hits_reg;
            out_left_x_reg  <= res_left_x_reg;
            out_left_y_reg  <= res_left_y_reg;
            out_right_x_reg <= res_right_x_reg;
            out_right_y_reg <= res_right_y_reg;
            out_mean_x_reg  <= quo_x[COORD_BITS-1:0];
            out_mean_y_reg  <= quo_y[COORD_BITS-1:0];
        end
    end

    assign status.last_pending = last_reg;
    assign status.out_free     = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign obstacle_found = out_found_reg;
    assign left_x         = out_left_x_reg;
    assign left_y         = out_left_y_reg;
    assign right_x        = out_right_x_reg;
    assign right_y        = out_right_y_reg;
    assign mean_x         = out_mean_x_reg;
    assign mean_y         = out_mean_y_reg;
    assign hit_count      = out_hits_reg;

endmodule

// ===== rtl/core/pord_ctrl.sv =====
// Controller: sequences point updates, end-of-frame division and the result beat.
module pord_ctrl #(
    parameter int DIV_STEPS = pord_pkg::COORD_BITS_DEF + pord_pkg::COUNT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pord_pkg::dp_status_t status,
    output pord_pkg::dp_cmd_t    cmd
);
    import pord_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_STEPS);

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                stall_int;
    logic                accept;

    assign stall_int = !((state_reg == ST_IDLE) ||
                         ((state_reg == ST_UPDATE) && !status.last_pending));
    assign accept    = in_valid && !stall_int;
    assign in_stall  = stall_int;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.load_in  = accept;
        cmd.update   = 1'b0;
        cmd.fin      = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.last_pending)
                    state_next = ST_FIN;
                else if (!accept)
                    state_next = ST_IDLE;
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/point_region_obstacle_detector_unit.sv =====
// Top level of the point region obstacle detector.
// Points stream in one beat per cycle while in_stall is low: each accepted
// point is tested and accumulated in the cycle after it is taken, while the
// next point is taken. A point marked frame_last stalls the input for the end
// of frame: its update, a snapshot, the shift-subtract dividers that form the
// means, and the load of the result beat once the output register is free.
// The result beat waits in an output register; a new frame streams while it
// is still stalled, and only the next end of frame waits for it to leave.
module point_region_obstacle_detector_unit #(
    parameter int COORD_BITS = pord_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pord_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [pord_pkg::DATA_BITS-1:0]     pwdata,
    output logic [pord_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_BITS-1:0]       point_x,
    input  logic signed [COORD_BITS-1:0]       point_y,
    input  logic signed [COORD_BITS-1:0]       point_z,
    input  logic                               point_valid,
    input  logic                               frame_last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               obstacle_found,
    output logic signed [COORD_BITS-1:0]       left_x,
    output logic signed [COORD_BITS-1:0]       left_y,
    output logic signed [COORD_BITS-1:0]       right_x,
    output logic signed [COORD_BITS-1:0]       right_y,
    output logic signed [COORD_BITS-1:0]       mean_x,
    output logic signed [COORD_BITS-1:0]       mean_y,
    output logic [pord_pkg::COUNT_BITS-1:0]    hit_count
);
    import pord_pkg::*;

    `include "point_region_obstacle_detector_unit_macros.svh"

    localparam int DIV_STEPS = COORD_BITS + COUNT_BITS;

    logic [BAND_BITS-1:0]   band_floor;
    logic [BAND_BITS-1:0]   band_height;
    logic [RADIUS_BITS-1:0] radius_squared;
    logic [COUNT_BITS-1:0]  count_threshold;
    dp_cmd_t                cmd;
    dp_status_t             status;

    pord_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .band_floor      (band_floor),
        .band_height     (band_height),
        .radius_squared  (radius_squared),
        .count_threshold (count_threshold)
    );

    pord_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pord_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .band_floor      (band_floor),
        .band_height     (band_height),
        .radius_squared  (radius_squared),
        .count_threshold (count_threshold),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .point_valid     (point_valid),
        .frame_last      (frame_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .obstacle_found  (obstacle_found),
        .left_x          (left_x),
        .left_y          (left_y),
        .right_x         (right_x),
        .right_y         (right_y),
        .mean_x          (mean_x),
        .mean_y          (mean_y),
        .hit_count       (hit_count)
    );

    `PORD_ASSERT(a_no_result_overwrite, cmd.out_load |-> (!out_valid || !out_stall), "result beat overwritten")
    `PORD_NEVER(a_no_accept_at_finish, cmd.fin && cmd.load_in, "point taken during frame finish")
    `PORD_ASSERT(a_divide_before_load, cmd.fin |=> !cmd.out_load, "result loaded before division")

endmodule

// ===== sim/point_region_obstacle_detector_unit_test.sv =====
// Testbench for the point region obstacle detector: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module point_region_obstacle_detector_unit_test;
    import pord_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int SETTLE      = 2 * (CW + 19);
    localparam int QUIET_LIMIT = 3000;
    localparam int RAND_POINTS = 950;
    localparam int NUM_PHASES  = 8;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   valid;
        logic   last;
    } point_t;

    typedef struct packed {
        logic                   found;
        coord_t                 left_x;
        coord_t                 left_y;
        coord_t                 right_x;
        coord_t                 right_y;
        coord_t                 mean_x;
        coord_t                 mean_y;
        logic [COUNT_BITS-1:0]  hit_count;
    } frame_result_t;

    typedef struct packed {
        logic [BAND_BITS-1:0]   band_floor;
        logic [BAND_BITS-1:0]   band_height;
        logic [RADIUS_BITS-1:0] radius_sq;
        logic [COUNT_BITS-1:0]  count_thr;
    } region_cfg_t;

    class obstacle_scoreboard;
        region_cfg_t   cfg;
        int            hits;
        bit            saturated;
        longint        sum_x;
        longint        sum_y;
        coord_t        least_y;
        coord_t        least_y_x;
        coord_t        most_y;
        coord_t        most_y_x;
        frame_result_t pending_frames[$];
        int            errors;
        int            frames_checked;
        int            points_taken;
        int            obstacles;

        function new();
            cfg.band_floor  = BAND_FLOOR_RST;
            cfg.band_height = BAND_HEIGHT_RST;
            cfg.radius_sq   = RADIUS_SQ_RST;
            cfg.count_thr   = THRESHOLD_RST;
            errors = 0;
            frames_checked = 0;
            points_taken = 0;
            obstacles = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            hits      = 0;
            saturated = 0;
            sum_x     = 0;
            sum_y     = 0;
            least_y   = {1'b0, {(CW-1){1'b1}}};
            least_y_x = '0;
            most_y    = {1'b1, {(CW-1){1'b0}}};
            most_y_x  = '0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_BITS-1:0] value);
            case (idx)
                REG_BAND_FLOOR:  cfg.band_floor  = value[BAND_BITS-1:0];
                REG_BAND_HEIGHT: cfg.band_height = value[BAND_BITS-1:0];
                REG_RADIUS_SQ:   cfg.radius_sq   = value[RADIUS_BITS-1:0];
                REG_THRESHOLD:   cfg.count_thr   = value[COUNT_BITS-1:0];
                default:         ;
            endcase
        endfunction

        function void note_point(coord_t x, coord_t y, coord_t z, logic valid, logic last);
            longint        lo;
            longint        hi;
            longint        r2;
            longint        taken;
            frame_result_t r;
            points_taken++;
            if (valid && !saturated) begin
                lo = longint'(cfg.band_floor);
                hi = lo + longint'(cfg.band_height);
                r2 = longint'(x) * longint'(x) + longint'(y) * longint'(y);
                if (z >= lo && z < hi && r2 < longint'(cfg.radius_sq)) begin
                    hits++;
                    if (hits >= cfg.count_thr) begin
                        saturated = 1;
                    end
                    else begin
                        sum_x += x;
                        sum_y += y;
                        if (y <= least_y) begin
                            least_y   = y;
                            least_y_x = x;
                        end
                        if (y >= most_y) begin
                            most_y   = y;
                            most_y_x = x;
                        end
                    end
                end
            end
            if (last) begin
                // the hit that trips the threshold is counted but not summed
                taken       = saturated ? hits - 1 : hits;
                r.found     = (hits >= cfg.count_thr);
                r.left_x    = least_y_x;
                r.left_y    = least_y;
                r.right_x   = most_y_x;
                r.right_y   = most_y;
                r.mean_x    = (taken != 0) ? coord_t'(sum_x / taken) : '0;
                r.mean_y    = (taken != 0) ? coord_t'(sum_y / taken) : '0;
                r.hit_count = hits[COUNT_BITS-1:0];
                if (r.found) obstacles++;
                pending_frames.push_back(r);
                clear_frame();
            end
        endfunction

        function void check_field(string name, logic signed [63:0] exp, logic signed [63:0] act);
            if (exp !== act) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t exp;
            if (pending_frames.size() == 0) begin
                $error("result beat with no frame pending");
                errors++;
                return;
            end
            exp = pending_frames.pop_front();
            frames_checked++;
            check_field("obstacle_found", exp.found, got.found);
            check_field("left_x", exp.left_x, got.left_x);
            check_field("left_y", exp.left_y, got.left_y);
            check_field("right_x", exp.right_x, got.right_x);
            check_field("right_y", exp.right_y, got.right_y);
            check_field("mean_x", exp.mean_x, got.mean_x);
            check_field("mean_y", exp.mean_y, got.mean_y);
            check_field("hit_count", exp.hit_count, got.hit_count);
        endfunction
    endclass

    // default config: band z in [15, 75), radius 230
    localparam point_t DIRECTED_POINTS [0:15] = '{
        '{0, 0, 20, 1'b0, 1'b1},
        '{32767, -32768, -32768, 1'b1, 1'b0},
        '{-32768, 32767, 32767, 1'b1, 1'b0},
        '{100, 50, 15, 1'b1, 1'b0},
        '{-100, 50, 74, 1'b1, 1'b0},
        '{10, 20, 75, 1'b1, 1'b0},
        '{230, 0, 40, 1'b1, 1'b0},
        '{229, 0, 40, 1'b1, 1'b0},
        '{-229, 0, 40, 1'b0, 1'b0},
        '{0, -160, 30, 1'b1, 1'b0},
        '{0, 0, 14, 1'b1, 1'b0},
        '{5, 5, 50, 1'b1, 1'b1},
        '{-1, -1, 16, 1'b1, 1'b1},
        '{7, -3, 20, 1'b1, 1'b0},
        '{-7, 3, 20, 1'b1, 1'b0},
        '{50, 50, 20, 1'b0, 1'b1}
    };

    localparam region_cfg_t FIXED_PHASES [0:5] = '{
        '{15, 60, 52900, 12},
        '{0, 32767, 32'hFFFF_FFFF, 5},
        '{32767, 32767, 32'h8000_0000, 16'hFFFF},
        '{100, 0, 100000, 3},
        '{0, 200, 0, 0},
        '{10, 100, 1000000, 0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_BITS-1:0]   paddr = '0;
    logic [DATA_BITS-1:0]   pwdata = '0;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    coord_t                 point_x = '0;
    coord_t                 point_y = '0;
    coord_t                 point_z = '0;
    logic                   point_valid = 1'b0;
    logic                   frame_last = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   obstacle_found;
    coord_t                 left_x;
    coord_t                 left_y;
    coord_t                 right_x;
    coord_t                 right_y;
    coord_t                 mean_x;
    coord_t                 mean_y;
    logic [COUNT_BITS-1:0]  hit_count;

    obstacle_scoreboard sb;
    frame_result_t      seen_frame;
    int                 burst_left = 0;
    int                 stall_left = 0;
    int                 quiet_cycles = 0;
    int                 phases_run = 0;

    always #4 clk = ~clk;

    point_region_obstacle_detector_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .point_valid    (point_valid),
        .frame_last     (frame_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .obstacle_found (obstacle_found),
        .left_x         (left_x),
        .left_y         (left_y),
        .right_x        (right_x),
        .right_y        (right_y),
        .mean_x         (mean_x),
        .mean_y         (mean_y),
        .hit_count      (hit_count)
    );

    // beat monitors
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            sb.note_point(point_x, point_y, point_z, point_valid, frame_last);
        end
        if (rst_n && out_valid && !out_stall) begin
            seen_frame.found     = obstacle_found;
            seen_frame.left_x    = left_x;
            seen_frame.left_y    = left_y;
            seen_frame.right_x   = right_x;
            seen_frame.right_y   = right_y;
            seen_frame.mean_x    = mean_x;
            seen_frame.mean_y    = mean_y;
            seen_frame.hit_count = hit_count;
            sb.check_result(seen_frame);
        end
    end

    // receiver stall: free runs, short blips and long holds
    always @(posedge clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    out_stall  <= 1'b0;
                    stall_left <= $urandom_range(1, 30);
                end
                4, 5, 6, 7, 8: begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(1, 3);
                end
                default: begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(10, 40);
                end
            endcase
        end
        else begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic apply_cfg(region_cfg_t c);
        apb_write(REG_BAND_FLOOR, DATA_BITS'(c.band_floor));
        apb_write(REG_BAND_HEIGHT, DATA_BITS'(c.band_height));
        apb_write(REG_RADIUS_SQ, DATA_BITS'(c.radius_sq));
        apb_write(REG_THRESHOLD, DATA_BITS'(c.count_thr));
    endtask

    task automatic send_point(point_t p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        point_x     <= p.x;
        point_y     <= p.y;
        point_z     <= p.z;
        point_valid <= p.valid;
        frame_last  <= p.last;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    // drain every frame, then let the divider finish before touching registers
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (sb.pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly points aimed at the current band and radius
    function automatic point_t pick_point();
        point_t p;
        int     kind;
        int     lim;
        int     span;
        kind    = $urandom_range(0, 99);
        p.x     = coord_t'($urandom);
        p.y     = coord_t'($urandom);
        p.z     = coord_t'($urandom);
        p.valid = !(kind >= 70 && kind < 82);
        p.last  = 1'b0;
        if (kind < 80) begin
            lim = int'($sqrt(real'(sb.cfg.radius_sq) / 2.0));
            if (lim > 32767) lim = 32767;
            p.x = coord_t'(int'($urandom_range(0, 2 * lim)) - lim);
            p.y = coord_t'(int'($urandom_range(0, 2 * lim)) - lim);
            if (sb.cfg.band_height != 0) begin
                span = int'(sb.cfg.band_height);
                if (sb.cfg.band_floor + span > 32768) span = 32768 - sb.cfg.band_floor;
                p.z = coord_t'(sb.cfg.band_floor + $urandom_range(0, span - 1));
            end
        end
        return p;
    endfunction

    task automatic run_frames(int n_points);
        int     sent;
        int     len;
        point_t p;
        sent = 0;
        while (sent < n_points) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                p = pick_point();
                p.last = (i == len - 1);
                send_point(p);
                sent++;
            end
        end
    endtask

    initial begin
        region_cfg_t c;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_POINTS[i]) send_point(DIRECTED_POINTS[i]);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 6) begin
                c = FIXED_PHASES[ph];
            end
            else begin
                c.band_floor  = BAND_BITS'($urandom_range(0, 200));
                c.band_height = BAND_BITS'($urandom_range(1, 400));
                c.radius_sq   = RADIUS_BITS'($urandom_range(2000, 3000000));
                c.count_thr   = COUNT_BITS'($urandom_range(1, 40));
            end
            apply_cfg(c);
            run_frames(RAND_POINTS / NUM_PHASES);
            settle();
            phases_run++;
        end

        if (sb.pending_frames.size() != 0) begin
            $error("%0d frames never reported", sb.pending_frames.size());
            sb.errors++;
        end
        $display("checked %0d frames from %0d points over %0d register settings",
                 sb.frames_checked, sb.points_taken, phases_run + 1);
        $display("%0d frames reached the obstacle count", sb.obstacles);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end
        else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
